// File: rtl/ewma_pkg.sv
package ewma_pkg;

    localparam int DATA_W = 16;
    localparam int NUM_W  = 2 * DATA_W;

    // Operation codes carried in the input item.
    localparam logic [1:0] OP_FILTER  = 2'd0;
    localparam logic [1:0] OP_FORCE   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_LENGTH  = 2'd1;
    localparam logic [1:0] REG_DEADBND = 2'd2;
    localparam logic [1:0] REG_LIMIT   = 2'd3;

    // Register values after reset.
    localparam logic              RST_ENABLE  = 1'b1;
    localparam logic [DATA_W-1:0] RST_LENGTH  = 16'd1;
    localparam logic [DATA_W-1:0] RST_DEADBND = 16'd0;
    localparam logic [DATA_W-1:0] RST_LIMIT   = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_AVERAGED = 3'd0,
        ST_FIRST    = 3'd1,
        ST_OUTLIER  = 3'd2,
        ST_JUMPED   = 3'd3,
        ST_HELD     = 3'd4,
        ST_RESET    = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]        operation;
        logic [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] average;
        logic [2:0]        status;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: rtl/ewma_div.sv
module ewma_div
    import ewma_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [DATA_W-1:0] r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [DATA_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DATA_W:0]   shifted;
    logic              ge;
    logic [DATA_W:0]   diff;

    // One restoring step per cycle: shift in the next dividend bit, then a
    // single compare and subtract against the divisor.
    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient never exceeds the larger of the old average and the
    // sample, so its low half is the whole result.
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo[DATA_W-1:0];

endmodule

// File: rtl/ewma_filter_clamp_deadband.sv
// Channel   Direction  Valid        Stall        Payload
// input     in         i_in_valid   o_in_stall   i_in_data  (t_in_item)
// output    out        o_out_valid  i_out_stall  o_out_data (t_out_item)
// config    in         i_cfg_we     -            i_cfg_index, i_cfg_data
//
// All items except a weighted update register their result at the transfer edge.
// A weighted update runs the multiply-add, loads the divider, takes 32 radix-2 divider steps
// and registers the quotient; the next input can transfer once the quotient is registered.
// The input stalls while an update is in progress and while a stalled result waits.
// Reset is synchronous and active low; it restores the register defaults, clears the
// average and sets the first-sample flag.
module ewma_filter_clamp_deadband
    import ewma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_state;

    t_state            r_state;
    logic              r_enable;
    logic [DATA_W-1:0] r_length;
    logic [DATA_W-1:0] r_deadbnd;
    logic [DATA_W-1:0] r_limit;
    logic [DATA_W-1:0] r_avg;
    logic              r_first;
    logic [DATA_W-1:0] r_sample;
    logic              r_out_valid;
    t_out_item         r_out;
    t_div_req          r_req;

    t_div_rsp          div_rsp;
    logic              in_xfer;
    logic              held_cfg;
    logic [DATA_W-1:0] distance;
    logic [DATA_W-1:0] n_avg;
    logic              n_first;
    t_status           n_status;
    logic              n_weighted;
    logic [NUM_W-1:0]  n_num;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign held_cfg = !r_enable || (r_length == '0) || (r_limit < r_deadbnd);
    assign distance = (i_in_data.value >= r_avg) ? (i_in_data.value - r_avg)
                                                 : (r_avg - i_in_data.value);

    always_comb begin
        n_avg      = r_avg;
        n_first    = r_first;
        n_status   = ST_HELD;
        n_weighted = 1'b0;
        unique case (i_in_data.operation)
            OP_FILTER: begin
                if (held_cfg) begin
                    n_status = ST_HELD;
                end else if (r_first) begin
                    n_avg    = i_in_data.value;
                    n_first  = 1'b0;
                    n_status = ST_FIRST;
                end else if (distance > r_limit) begin
                    n_status = ST_OUTLIER;
                end else if (distance > r_deadbnd) begin
                    n_avg    = i_in_data.value;
                    n_status = ST_JUMPED;
                end else begin
                    n_status   = ST_AVERAGED;
                    n_weighted = 1'b1;
                end
            end
            OP_FORCE: begin
                n_avg    = i_in_data.value;
                n_first  = 1'b0;
                n_status = ST_RESET;
            end
            OP_RESTART: begin
                if (r_enable && (r_length != '0)) begin
                    n_avg    = i_in_data.value;
                    n_first  = 1'b1;
                    n_status = ST_RESET;
                end
            end
            default: begin
                n_status = ST_HELD;
            end
        endcase
    end

    // Full-width multiply-add; the sum stays below 2^32.
    assign n_num = (NUM_W'(r_avg) * NUM_W'(r_length - DATA_W'(1))) + NUM_W'(r_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= RST_ENABLE;
            r_length    <= RST_LENGTH;
            r_deadbnd   <= RST_DEADBND;
            r_limit     <= RST_LIMIT;
            r_avg       <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_req.start <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ENABLE:  r_enable  <= i_cfg_data[0];
                    REG_LENGTH:  r_length  <= i_cfg_data;
                    REG_DEADBND: r_deadbnd <= i_cfg_data;
                    REG_LIMIT:   r_limit   <= i_cfg_data;
                    default:     r_enable  <= r_enable;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (n_weighted) begin
                            r_sample <= i_in_data.value;
                            r_state  <= S_MUL;
                        end else begin
                            r_avg              <= n_avg;
                            r_first            <= n_first;
                            r_out.average      <= n_avg;
                            r_out.status       <= n_status;
                            r_out_valid        <= 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    r_req.start <= 1'b1;
                    r_req.num   <= n_num;
                    r_req.den   <= r_length;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_avg         <= div_rsp.quot;
                        r_out.average <= div_rsp.quot;
                        r_out.status  <= ST_AVERAGED;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    ewma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/ewma_chk.sv
module ewma_chk
    import ewma_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input t_in_item          i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_item         o_out_data
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // A waiting result blocks the next input transfer.
    a_no_accept_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while a result waits");

    // A forced value appears on the output right after its transfer.
    a_force_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.operation == OP_FORCE) |=>
        (o_out_valid && o_out_data.average == $past(i_in_data.value)
         && o_out_data.status == ST_RESET))
        else $error("force result wrong");

    // An unknown operation leaves a held result at once.
    a_unknown_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.operation != OP_FILTER && i_in_data.operation != OP_FORCE
         && i_in_data.operation != OP_RESTART) |=>
        (o_out_valid && o_out_data.status == ST_HELD))
        else $error("unknown operation not held");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped under stall");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output payload changed under stall");

endmodule

bind ewma_filter_clamp_deadband ewma_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: verif/ewma_filter_clamp_deadband_tb.sv
`timescale 1ns / 1ps

module ewma_filter_clamp_deadband_tb
    import ewma_pkg::*;
;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 680;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic              typed;
        logic [DATA_W-1:0] average;
        logic [2:0]        status;
    } t_known_result;

    typedef struct packed {
        logic              reg_write;
        logic [1:0]        code;
        logic [DATA_W-1:0] value;
        logic              typed;
        logic [DATA_W-1:0] average;
        t_status           status;
    } t_step;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              i_cfg_we    = 1'b0;
    logic [1:0]        i_cfg_index = REG_ENABLE;
    logic [DATA_W-1:0] i_cfg_data  = '0;

    ewma_filter_clamp_deadband dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Filter state and register copies tracked by the scoreboard.
    logic              cfg_enable;
    logic [DATA_W-1:0] cfg_length;
    logic [DATA_W-1:0] cfg_deadband;
    logic [DATA_W-1:0] cfg_limit;
    logic [DATA_W-1:0] model_avg;
    logic              model_first;

    t_out_item     expected_results[$];
    t_known_result known_result = '0;
    t_step         script[$];

    int  cycle_count    = 0;
    int  mismatches     = 0;
    int  items_taken    = 0;
    int  results_checked = 0;
    int  status_seen[8];
    bit  calm_in        = 1'b0;
    bit  out_calm       = 1'b0;
    int  out_run        = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] clip16(int v);
        if (v < 0) return '0;
        if (v > 65535) return '1;
        return v[DATA_W-1:0];
    endfunction

    function automatic t_step step_op(logic [1:0] op, logic [DATA_W-1:0] data);
        step_op = '{reg_write: 1'b0, code: op, value: data, typed: 1'b0,
                    average: '0, status: ST_HELD};
    endfunction

    function automatic t_step step_known(logic [1:0] op, logic [DATA_W-1:0] data,
                                         logic [DATA_W-1:0] avg, t_status st);
        step_known = '{reg_write: 1'b0, code: op, value: data, typed: 1'b1,
                       average: avg, status: st};
    endfunction

    function automatic t_step step_cfg(logic [1:0] idx, logic [DATA_W-1:0] data);
        step_cfg = '{reg_write: 1'b1, code: idx, value: data, typed: 1'b0,
                     average: '0, status: ST_HELD};
    endfunction

    // Advances the tracked filter state by one item and returns its result.
    function automatic t_out_item ewma_predict(t_in_item item);
        logic [DATA_W-1:0] distance;
        logic [NUM_W-1:0]  num;
        t_status           st;
        case (item.operation)
            OP_FILTER: begin
                if (!cfg_enable || cfg_length == '0 || cfg_limit < cfg_deadband) begin
                    st = ST_HELD;
                end else if (model_first) begin
                    model_avg   = item.value;
                    model_first = 1'b0;
                    st          = ST_FIRST;
                end else begin
                    distance = (item.value >= model_avg) ? item.value - model_avg
                                                         : model_avg - item.value;
                    if (distance > cfg_limit) begin
                        st = ST_OUTLIER;
                    end else if (distance > cfg_deadband) begin
                        model_avg = item.value;
                        st        = ST_JUMPED;
                    end else begin
                        num = NUM_W'(model_avg) * NUM_W'(cfg_length - 16'd1)
                            + NUM_W'(item.value);
                        model_avg = DATA_W'(num / NUM_W'(cfg_length));
                        st        = ST_AVERAGED;
                    end
                end
            end
            OP_FORCE: begin
                model_avg   = item.value;
                model_first = 1'b0;
                st          = ST_RESET;
            end
            OP_RESTART: begin
                if (cfg_enable && cfg_length != '0) begin
                    model_avg   = item.value;
                    model_first = 1'b1;
                    st          = ST_RESET;
                end else begin
                    st = ST_HELD;
                end
            end
            default: st = ST_HELD;
        endcase
        ewma_predict = '{average: model_avg, status: st};
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < 50) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_out_item got;
        t_out_item want;
        t_out_item pred;
        if (!i_rst_n) begin
            cfg_enable   = RST_ENABLE;
            cfg_length   = RST_LENGTH;
            cfg_deadband = RST_DEADBND;
            cfg_limit    = RST_LIMIT;
            model_avg    = '0;
            model_first  = 1'b1;
        end else begin
            // Results are retired before the new transfer is predicted.
            if (o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("result avg %h status %0d with none pending",
                                            got.average, got.status));
                end else begin
                    want = expected_results.pop_front();
                    if (got.average !== want.average)
                        flag_mismatch($sformatf("average %h, predicted %h",
                                                got.average, want.average));
                    if (got.status !== want.status)
                        flag_mismatch($sformatf("status %0d, predicted %0d",
                                                got.status, want.status));
                    results_checked++;
                    status_seen[want.status]++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ENABLE:  cfg_enable   = i_cfg_data[0];
                    REG_LENGTH:  cfg_length   = i_cfg_data;
                    REG_DEADBND: cfg_deadband = i_cfg_data;
                    REG_LIMIT:   cfg_limit    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                pred = ewma_predict(i_in_data);
                if (known_result.typed)
                    expected_results.push_back('{average: known_result.average,
                                                 status: known_result.status});
                else
                    expected_results.push_back(pred);
                items_taken++;
            end
        end
    end

    always @(posedge i_clk) begin : out_pacing
        if ($urandom_range(0, 399) == 0) out_calm = ~out_calm;
        if (out_run != 0) begin
            out_run--;
        end else if (i_out_stall || out_calm) begin
            i_out_stall <= 1'b0;
            out_run = $urandom_range(0, 6);
        end else begin
            out_run = pick_gap();
            i_out_stall <= (out_run != 0);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Holds the payload until the transfer; valid stays high for a back-to-back item.
    task automatic send_item(input t_in_item item, input t_known_result kr);
        int gap;
        gap = calm_in ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_data    <= item;
        known_result <= kr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[DATA_W-1:0];
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_in_item      item;
        t_known_result kr;
        int            directed;
        int            sent;
        int            settings;
        int            phase_len;
        int            en, len, db, lim, spread, off, center, r;

        directed = 0;
        sent     = 0;
        settings = 1;
        center   = 16'h4000;

        // Reset defaults first: unit length and zero deadband.
        script.push_back(step_known(OP_FILTER,  16'h1234, 16'h1234, ST_FIRST));
        script.push_back(step_op   (OP_FILTER,  16'h1234));
        script.push_back(step_known(OP_FILTER,  16'hFFFF, 16'hFFFF, ST_JUMPED));
        script.push_back(step_known(OP_FILTER,  16'h0000, 16'h0000, ST_JUMPED));
        script.push_back(step_known(OP_FORCE,   16'hFFFF, 16'hFFFF, ST_RESET));
        script.push_back(step_known(OP_RESTART, 16'h0000, 16'h0000, ST_RESET));
        script.push_back(step_known(OP_FILTER,  16'hFFFF, 16'hFFFF, ST_FIRST));
        script.push_back(step_known(OP_UNUSED,  16'h5555, 16'hFFFF, ST_HELD));
        script.push_back(step_known(OP_FORCE,   16'hAAAA, 16'hAAAA, ST_RESET));
        script.push_back(step_known(OP_FORCE,   16'h5555, 16'h5555, ST_RESET));
        // Disabled: samples and restarts hold, a force still loads.
        script.push_back(step_cfg  (REG_ENABLE, 16'd0));
        script.push_back(step_known(OP_FILTER,  16'h1111, 16'h5555, ST_HELD));
        script.push_back(step_known(OP_RESTART, 16'h2222, 16'h5555, ST_HELD));
        script.push_back(step_known(OP_FORCE,   16'h0000, 16'h0000, ST_RESET));
        // Zero length holds as well.
        script.push_back(step_cfg  (REG_ENABLE, 16'd1));
        script.push_back(step_cfg  (REG_LENGTH, 16'd0));
        script.push_back(step_known(OP_FILTER,  16'h1234, 16'h0000, ST_HELD));
        script.push_back(step_known(OP_RESTART, 16'h4321, 16'h0000, ST_HELD));
        // Longest length with the widest deadband: full-width product.
        script.push_back(step_cfg  (REG_LENGTH, 16'hFFFF));
        script.push_back(step_cfg  (REG_DEADBND, 16'hFFFF));
        script.push_back(step_cfg  (REG_LIMIT,  16'hFFFF));
        script.push_back(step_known(OP_FORCE,   16'hFFFF, 16'hFFFF, ST_RESET));
        script.push_back(step_op   (OP_FILTER,  16'h0000));
        script.push_back(step_op   (OP_FILTER,  16'hFFFF));
        // A limit below the deadband holds; a zero limit drops any change.
        script.push_back(step_cfg  (REG_DEADBND, 16'd1));
        script.push_back(step_cfg  (REG_LIMIT,  16'd0));
        script.push_back(step_known(OP_FORCE,   16'h8000, 16'h8000, ST_RESET));
        script.push_back(step_known(OP_FILTER,  16'h8001, 16'h8000, ST_HELD));
        script.push_back(step_cfg  (REG_DEADBND, 16'd0));
        script.push_back(step_known(OP_FILTER,  16'h8001, 16'h8000, ST_OUTLIER));
        script.push_back(step_op   (OP_FILTER,  16'h8000));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].reg_write) begin
                if (i == 0 || !script[i-1].reg_write) begin
                    drain();
                    settings++;
                end
                write_reg(script[i].code, script[i].value);
                if (i == script.size() - 1 || !script[i+1].reg_write) i_cfg_we <= 1'b0;
            end else begin
                item = '{operation: script[i].code, value: script[i].value};
                kr   = '{typed: script[i].typed, average: script[i].average,
                         status: script[i].status};
                send_item(item, kr);
                directed++;
            end
        end

        while (sent < RANDOM_ITEMS) begin
            drain();
            en = ($urandom_range(0, 15) != 0);
            case ($urandom_range(0, 9))
                0:       len = 0;
                1, 2:    len = 1;
                3, 4, 5: len = $urandom_range(2, 16);
                6:       len = $urandom_range(17, 1024);
                7:       len = $urandom_range(1025, 65534);
                default: len = 65535;
            endcase
            case ($urandom_range(0, 7))
                0:          db = 0;
                1, 2, 3:    db = $urandom_range(1, 64);
                4, 5:       db = $urandom_range(65, 4000);
                6:          db = $urandom_range(0, 65535);
                default:    db = 65535;
            endcase
            case ($urandom_range(0, 9))
                0:       lim = 0;
                1:       lim = (db > 0) ? db - 1 : 0;
                2, 3:    lim = 65535;
                4:       lim = $urandom_range(0, 65535);
                default: lim = clip16(db + $urandom_range(0, 3000));
            endcase
            write_reg(REG_ENABLE, en);
            write_reg(REG_LENGTH, len);
            write_reg(REG_DEADBND, db);
            write_reg(REG_LIMIT, lim);
            i_cfg_we <= 1'b0;
            settings++;
            calm_in   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(30, 70);
            spread    = (db > 1000) ? 1000 : db;

            // Mostly samples around a drifting level, so the average settles
            // and the weighted path runs; the rest jumps, drops and reloads.
            repeat (phase_len) begin
                if ($urandom_range(0, 49) == 0) center = $urandom_range(0, 65535);
                center = clip16(center + $urandom_range(0, 8) - 4);
                r = $urandom_range(0, 99);
                item.operation = OP_FILTER;
                if (r < 65) begin
                    off        = $urandom_range(0, spread);
                    item.value = clip16($urandom_range(0, 1) ? center + off : center - off);
                end else if (r < 75) begin
                    off        = db + $urandom_range(1, 200);
                    item.value = clip16($urandom_range(0, 1) ? center + off : center - off);
                end else if (r < 83) begin
                    item.value = DATA_W'($urandom_range(0, 65535));
                end else if (r < 87) begin
                    item.value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end else if (r < 92) begin
                    item.operation = OP_FORCE;
                    item.value     = DATA_W'($urandom_range(0, 65535));
                    center         = item.value;
                end else if (r < 97) begin
                    item.operation = OP_RESTART;
                    item.value     = DATA_W'($urandom_range(0, 65535));
                    center         = item.value;
                end else begin
                    item.operation = OP_UNUSED;
                    item.value     = DATA_W'($urandom_range(0, 65535));
                end
                send_item(item, '0);
                sent++;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d items sent (%0d directed), %0d results checked, %0d register settings",
                 items_taken, directed, results_checked, settings);
        $display("results: averaged %0d, first %0d, outlier %0d, jumped %0d, held %0d, reload %0d",
                 status_seen[ST_AVERAGED], status_seen[ST_FIRST], status_seen[ST_OUTLIER],
                 status_seen[ST_JUMPED], status_seen[ST_HELD], status_seen[ST_RESET]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: ewma_filter_clamp_deadband.f
rtl/ewma_pkg.sv
rtl/ewma_div.sv
rtl/ewma_filter_clamp_deadband.sv
rtl/ewma_chk.sv
verif/ewma_filter_clamp_deadband_tb.sv
